// ===== hdl/utf8d_pkg.sv =====
// ============================================================================
// utf8d_pkg
// Shared types, constants and helper functions for the UTF-8 stream decoder.
// ============================================================================
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  // Open sequence length codes.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  localparam logic [CpW-1:0] REPL_CP       = 21'h00FFFD;
  localparam logic [CpW-1:0] MIN_2BYTE_CP  = 21'h000080;
  localparam logic [CpW-1:0] MIN_3BYTE_CP  = 21'h000800;
  localparam logic [CpW-1:0] SURR_LO_CP    = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI_CP    = 21'h00DFFF;
  localparam logic [CpW-1:0] MIN_4BYTE_CP  = 21'h010000;
  localparam logic [CpW-1:0] MAX_CP        = 21'h10FFFF;

  // All results caused by one input byte: a number of replacement characters
  // followed by an optional final result.
  typedef struct packed {
    logic [1:0]     repl_cnt;
    logic           tail_vld;
    logic [CpW-1:0] tail_cp;
    logic           tail_eot;
  } run_t;

  // One result as presented on the output channel.
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           eot;
    logic           last;
  } result_t;

  function automatic logic run_busy(input run_t r);
    return (r.repl_cnt != 2'd0) || r.tail_vld;
  endfunction

  function automatic result_t run_head(input run_t r);
    result_t res;
    if (r.repl_cnt != 2'd0) begin
      res.cp   = REPL_CP;
      res.eot  = 1'b0;
      res.last = (r.repl_cnt == 2'd1) && !r.tail_vld;
    end else begin
      res.cp   = r.tail_cp;
      res.eot  = r.tail_eot;
      res.last = 1'b1;
    end
    return res;
  endfunction

  function automatic run_t run_rest(input run_t r);
    run_t rest;
    rest = r;
    if (r.repl_cnt != 2'd0) begin
      rest.repl_cnt = r.repl_cnt - 2'd1;
    end else begin
      rest.tail_vld = 1'b0;
    end
    return rest;
  endfunction

endpackage

// ===== hdl/utf8d_decode.sv =====
// ============================================================================
// utf8d_decode
// Sequence state and byte decoder: turns one byte into a run of results.
// ============================================================================
module utf8d_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_acc,
  input  logic [7:0]         text_byte,
  output utf8d_pkg::run_t    run
);

  logic [2:0]                  exp_len_r, exp_len_nxt;
  logic [1:0]                  seen_r, seen_nxt;
  logic [utf8d_pkg::CpW-1:0]   partial_r, partial_nxt;

  logic                        is_cont;
  logic                        seq_open;
  logic [2:0]                  seen_inc;
  logic [utf8d_pkg::CpW-1:0]   shifted;
  logic [utf8d_pkg::CpW-1:0]   checked;
  logic                        bad_cp;

  assign is_cont  = (text_byte[7:6] == 2'b10);
  assign seq_open = (exp_len_r != utf8d_pkg::LEN_NONE);
  assign seen_inc = {1'b0, seen_r} + 3'd1;
  assign shifted  = {partial_r[utf8d_pkg::CpW-7:0], text_byte[5:0]};

  always_comb begin
    case (exp_len_r)
      utf8d_pkg::LEN_2: bad_cp = shifted < utf8d_pkg::MIN_2BYTE_CP;
      utf8d_pkg::LEN_3: bad_cp = (shifted < utf8d_pkg::MIN_3BYTE_CP) ||
                                 ((shifted >= utf8d_pkg::SURR_LO_CP) &&
                                  (shifted <= utf8d_pkg::SURR_HI_CP));
      default:          bad_cp = (shifted < utf8d_pkg::MIN_4BYTE_CP) ||
                                 (shifted > utf8d_pkg::MAX_CP);
    endcase
    checked = bad_cp ? utf8d_pkg::REPL_CP : shifted;
  end

  always_comb begin
    run          = '0;
    exp_len_nxt  = exp_len_r;
    seen_nxt     = seen_r;
    partial_nxt  = partial_r;
    if (seq_open && is_cont) begin
      if ((seen_inc + 3'd1) >= exp_len_r) begin
        run.tail_vld = 1'b1;
        run.tail_cp  = checked;
        exp_len_nxt  = utf8d_pkg::LEN_NONE;
        seen_nxt     = 2'd0;
        partial_nxt  = '0;
      end else begin
        seen_nxt    = seen_inc[1:0];
        partial_nxt = shifted;
      end
    end else begin
      // A broken sequence flushes the lead and its buffered continuations.
      if (seq_open) begin
        run.repl_cnt = (seen_r > 2'd2) ? 2'd3 : seen_r + 2'd1;
      end
      exp_len_nxt = utf8d_pkg::LEN_NONE;
      seen_nxt    = 2'd0;
      partial_nxt = '0;
      if (text_byte == 8'h00) begin
        run.tail_vld = 1'b1;
        run.tail_eot = 1'b1;
      end else if (!text_byte[7]) begin
        run.tail_vld = 1'b1;
        run.tail_cp  = {13'd0, text_byte};
      end else if (is_cont) begin
        run.tail_vld = 1'b1;
        run.tail_cp  = utf8d_pkg::REPL_CP;
      end else if (text_byte[7:5] == 3'b110) begin
        exp_len_nxt = utf8d_pkg::LEN_2;
        partial_nxt = {16'd0, text_byte[4:0]};
      end else if (text_byte[7:4] == 4'b1110) begin
        exp_len_nxt = utf8d_pkg::LEN_3;
        partial_nxt = {17'd0, text_byte[3:0]};
      end else if (text_byte[7:3] == 5'b11110) begin
        exp_len_nxt = utf8d_pkg::LEN_4;
        partial_nxt = {18'd0, text_byte[2:0]};
      end else begin
        run.tail_vld = 1'b1;
        run.tail_cp  = utf8d_pkg::REPL_CP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= utf8d_pkg::LEN_NONE;
      seen_r    <= 2'd0;
      partial_r <= '0;
    end else if (byte_acc) begin
      exp_len_r <= exp_len_nxt;
      seen_r    <= seen_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

// ===== hdl/utf8d_out_buf.sv =====
// ============================================================================
// utf8d_out_buf
// Run buffer and output register: hands out one result per request.
// ============================================================================
module utf8d_out_buf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  utf8d_pkg::run_t            run_in,
  output logic                       buf_free,
  output logic                       res_vld,
  input  logic                       res_rdy,
  output utf8d_pkg::result_t         res
);

  utf8d_pkg::run_t    pend_r;
  utf8d_pkg::result_t res_r;
  logic               res_vld_r;
  logic               take;
  logic               pend_busy;

  assign pend_busy = utf8d_pkg::run_busy(pend_r);
  assign take      = !res_vld_r || res_rdy;
  assign buf_free  = !pend_busy;
  assign res_vld   = res_vld_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r       <= 1'b0;
      pend_r.repl_cnt <= 2'd0;
      pend_r.tail_vld <= 1'b0;
    end else if (take) begin
      if (pend_busy) begin
        res_vld_r <= 1'b1;
        res_r     <= utf8d_pkg::run_head(pend_r);
        pend_r    <= utf8d_pkg::run_rest(pend_r);
      end else if (load && utf8d_pkg::run_busy(run_in)) begin
        // The first result skips the buffer so single results stream.
        res_vld_r <= 1'b1;
        res_r     <= utf8d_pkg::run_head(run_in);
        pend_r    <= utf8d_pkg::run_rest(run_in);
      end else begin
        res_vld_r <= 1'b0;
      end
    end else if (load) begin
      pend_r <= run_in;
    end
  end

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// ============================================================================
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte in, zero to four code points out.
// ============================================================================
//
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, in_text_byte[7:0]        | input
//  out     | out_valid, out_ready, out_code_point[20:0],  | output
//          | out_end_of_text, out_last_of_run             |
//
// A byte is decoded in the cycle it is accepted. When the output register is
// free or drained in that cycle, its first result lands there directly and a
// byte with at most one result streams at one byte per cycle.
// A byte with several results (a broken sequence) holds the input while the
// results beyond the first wait in the run buffer. Lead bytes and buffered
// continuation bytes produce no result. The input stalls only while the run
// buffer still holds results.
// Reset (synchronous, active low) closes any open sequence and empties the
// output side; it takes effect at the next rising edge.
//
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_end_of_text,
  output logic        out_last_of_run
);

  utf8d_pkg::run_t    dec_run;
  utf8d_pkg::result_t res;
  logic               buf_free;
  logic               in_acc;

  // A request is taken whenever the run buffer holds nothing; results already
  // in the output register do not block it.
  assign in_ready = buf_free;
  assign in_acc   = in_valid && buf_free;

  utf8d_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (in_acc),
    .text_byte (in_text_byte),
    .run       (dec_run)
  );

  utf8d_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_acc),
    .run_in   (dec_run),
    .buf_free (buf_free),
    .res_vld  (out_valid),
    .res_rdy  (out_ready),
    .res      (res)
  );

  assign out_code_point  = res.cp;
  assign out_end_of_text = res.eot;
  assign out_last_of_run = res.last;

`ifndef SYNTHESIS
  // Pending results always sit behind a valid output register.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("run buffer holds results while output register is empty");

  // The end result is always the final result of its byte, with code 0.
  a_eot_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_text) |-> (out_last_of_run && out_code_point == 21'd0))
    else $error("malformed end of text result");

  // Only replacement characters precede the last result of a run.
  a_prefix_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> (out_code_point == utf8d_pkg::REPL_CP))
    else $error("non-final result is not a replacement character");

  // An accepted result that is not the last of its run is followed by another result.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=> out_valid)
    else $error("run ended without its last result");
`endif

endmodule

// ===== tb/utf8d_tb_pkg.sv =====
// ============================================================================
// utf8d_tb_pkg
// Scoreboard for the UTF-8 stream decoder. It keeps its own copy of the
// decoder state, predicts the code points that each accepted request causes,
// and checks the results in order as they leave the block.
// ============================================================================
package utf8d_tb_pkg;

  localparam int unsigned CpW = utf8d_pkg::CpW;

  class utf8_decode_scoreboard;

    // Decoder state as the predictor sees it.
    logic [2:0]     seq_len;
    logic [1:0]     conts_held;
    logic [CpW-1:0] partial_cp;

    utf8d_pkg::result_t expected_q[$];
    int                 errors;
    int                 n_checked;

    function new();
      close_seq();
      errors    = 0;
      n_checked = 0;
    endfunction

    function void close_seq();
      seq_len    = utf8d_pkg::LEN_NONE;
      conts_held = 2'd0;
      partial_cp = '0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // A finished sequence stands only if it is the shortest form of a scalar
    // value that is neither a surrogate nor above the Unicode range.
    function logic [CpW-1:0] scalar_or_repl(logic [2:0] len, logic [CpW-1:0] cp);
      case (len)
        utf8d_pkg::LEN_2: begin
          if (cp < utf8d_pkg::MIN_2BYTE_CP) return utf8d_pkg::REPL_CP;
        end
        utf8d_pkg::LEN_3: begin
          if (cp < utf8d_pkg::MIN_3BYTE_CP ||
              (cp >= utf8d_pkg::SURR_LO_CP && cp <= utf8d_pkg::SURR_HI_CP))
            return utf8d_pkg::REPL_CP;
        end
        default: begin
          if (cp < utf8d_pkg::MIN_4BYTE_CP || cp > utf8d_pkg::MAX_CP)
            return utf8d_pkg::REPL_CP;
        end
      endcase
      return cp;
    endfunction

    // Works out every result that one accepted byte causes and queues them.
    function void note_byte(logic [7:0] b);
      utf8d_pkg::result_t run[$];
      utf8d_pkg::result_t r;
      logic               is_cont;
      is_cont = (b[7:6] == 2'b10);
      r.eot   = 1'b0;
      r.last  = 1'b0;

      if (seq_len != utf8d_pkg::LEN_NONE) begin
        if (is_cont) begin
          partial_cp = {partial_cp[CpW-7:0], b[5:0]};
          if (int'(conts_held) + 2 >= int'(seq_len)) begin
            r.cp   = scalar_or_repl(seq_len, partial_cp);
            r.last = 1'b1;
            expected_q.push_back(r);
            close_seq();
            return;
          end
          conts_held = conts_held + 2'd1;
          return;
        end
        // The sequence is broken: one replacement for the lead and one for
        // each continuation byte buffered so far.
        r.cp = utf8d_pkg::REPL_CP;
        run.push_back(r);
        for (int i = 0; i < int'(conts_held); i++) run.push_back(r);
        close_seq();
      end

      casez (b)
        8'b0000_0000: begin
          r.cp  = '0;
          r.eot = 1'b1;
          run.push_back(r);
        end
        8'b0???_????: begin
          r.cp = CpW'(b);
          run.push_back(r);
        end
        8'b10??_????: begin
          r.cp = utf8d_pkg::REPL_CP;
          run.push_back(r);
        end
        8'b110?_????: begin
          seq_len    = utf8d_pkg::LEN_2;
          partial_cp = CpW'(b[4:0]);
        end
        8'b1110_????: begin
          seq_len    = utf8d_pkg::LEN_3;
          partial_cp = CpW'(b[3:0]);
        end
        8'b1111_0???: begin
          seq_len    = utf8d_pkg::LEN_4;
          partial_cp = CpW'(b[2:0]);
        end
        default: begin
          r.cp = utf8d_pkg::REPL_CP;
          run.push_back(r);
        end
      endcase

      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) expected_q.push_back(run[i]);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch: %s", what);
    endtask

    task check_result(logic [CpW-1:0] cp, logic eot, logic last);
      utf8d_pkg::result_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d unexpected: code_point %h end %b last %b",
                         n_checked, cp, eot, last));
        return;
      end
      want = expected_q.pop_front();
      if (cp !== want.cp)
        report($sformatf("result %0d code_point %h, expected %h", n_checked, cp, want.cp));
      if (eot !== want.eot)
        report($sformatf("result %0d end_of_text %b, expected %b", n_checked, eot, want.eot));
      if (last !== want.last)
        report($sformatf("result %0d last_of_run %b, expected %b", n_checked, last, want.last));
    endtask

  endclass

endpackage

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Testbench for utf8_stream_decoder. A directed text covers the byte extremes
// and the decoding cases listed below, then random text made mostly of whole sequences
// with random content, mixed with broken sequences and noise, runs with
// random gaps on the input side and random stalls on the result side.
// ============================================================================
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // Byte patterns used to build text.
  localparam logic [7:0] LEAD2_TAG = 8'hC0;
  localparam logic [7:0] LEAD3_TAG = 8'hE0;
  localparam logic [7:0] LEAD4_TAG = 8'hF0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] EOT_BYTE  = 8'h00;

  localparam int RANDOM_BYTES = 445;
  localparam int PAUSE_AT     = 240;
  localparam int MAX_WAIT     = 12;
  // Cycles in a row with no handshake on either side before the run is
  // declared hung. A correct run never goes past a gap or a stall of
  // MAX_WAIT plus the drain of the results of a broken-sequence run.
  localparam int HANG_LIMIT   = 2000;
  localparam int SETTLE       = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_text_byte;
  logic        out_valid;
  logic        out_ready;
  logic [20:0] out_code_point;
  logic        out_end_of_text;
  logic        out_last_of_run;

  utf8d_tb_pkg::utf8_decode_scoreboard sb;

  // Burst flags switch off idling on one side for a stretch of requests.
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;
  int n_sent    = 0;
  int idle_cycles = 0;

  logic [7:0] directed_text[$];

  utf8_stream_decoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  // Offers one byte after a random gap and holds it until the block takes it.
  // It is entered and left just after a falling edge, so valid is never
  // lowered and raised again in the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    n_sent++;
    @(negedge clk);
  endtask

  // Holds the input off until every predicted code point has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic logic [7:0] random_lead(input int len);
    case (len)
      2:       return LEAD2_TAG | 8'($urandom_range(0, 31));
      3:       return LEAD3_TAG | 8'($urandom_range(0, 15));
      default: return LEAD4_TAG | 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [7:0] random_cont();
    return CONT_TAG | 8'($urandom_range(0, 63));
  endfunction

  // Any byte that is not a continuation byte; end of text now and then.
  function automatic logic [7:0] random_breaker();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
    if ($urandom_range(0, 3) == 0) b = EOT_BYTE;
    return b;
  endfunction

  // Main stimulus: reset, directed text, random text, then the final verdict.
  initial begin : stimulus
    int pick;
    int seq_bytes;
    bit paused_once;
    paused_once  = 1'b0;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_byte = 8'h00;

    // Directed text: byte extremes, a stray continuation, a bad lead, one
    // good sequence of each length, an overlong two-byte form, a lead above
    // the Unicode range, a sequence broken by an ASCII byte, and a four-byte
    // sequence broken by the end of text with two continuations buffered.
    directed_text = '{8'h7F, 8'h80, 8'hFF, 8'hF8,
                      8'hC3, 8'hA9,
                      8'hC0, 8'h80,
                      8'hE2, 8'h82, 8'hAC,
                      8'hF0, 8'h9F, 8'h98, 8'h80,
                      8'hF5, 8'h80, 8'h80, 8'h80,
                      8'hE2, 8'h82, 8'h41,
                      8'hF0, 8'h9F, 8'h98, 8'h00};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_text[i]) send_byte(directed_text[i]);

    // Random text. Most of it is whole sequences with random lead and
    // continuation bits, which also lands on overlong forms, surrogates and
    // values above the Unicode range. The rest is ASCII, broken sequences,
    // raw noise and end-of-text bytes.
    while (n_sent < directed_text.size() + RANDOM_BYTES) begin
      if (!paused_once && n_sent >= PAUSE_AT) begin
        wait_for_drain();
        paused_once = 1'b1;
      end
      pick      = $urandom_range(0, 99);
      seq_bytes = $urandom_range(2, 4);
      if (pick < 25) begin
        send_byte(8'($urandom_range(1, 127)));
      end else if (pick < 70) begin
        send_byte(random_lead(seq_bytes));
        repeat (seq_bytes - 1) send_byte(random_cont());
      end else if (pick < 82) begin
        send_byte(random_lead(seq_bytes));
        repeat ($urandom_range(0, seq_bytes - 2)) send_byte(random_cont());
        send_byte(random_breaker());
      end else if (pick < 95) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(EOT_BYTE);
      end
    end

    // Let the last results drain, then keep watching the output for anything
    // it should not produce.
    wait_for_drain();
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0) begin
      $display("** utf8_stream_decoder: PASSED **");
    end else begin
      $display("** utf8_stream_decoder: FAILED **");
    end
    $finish;
  end

  // Result side: before each result, ready may drop for a random stall, and each
  // accepted result goes to the scoreboard. It waits for a clean release of
  // reset, since reset is still unknown in the first moments of the run.
  initial begin : drain_results
    int stall;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_code_point, out_end_of_text, out_last_of_run);
      @(negedge clk);
    end
  end

  // Watchdog: counts cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("no handshake for %0d cycles", HANG_LIMIT);
        $display("** utf8_stream_decoder: FAILED **");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
hdl/utf8d_pkg.sv
hdl/utf8d_decode.sv
hdl/utf8d_out_buf.sv
hdl/utf8_stream_decoder.sv
tb/utf8d_tb_pkg.sv
tb/tb_top.sv
